// File: sv/lc3x_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_pkg
// Shared types and constants for the LC-3 execute unit.
// ----------------------------------------------------------------------------
package lc3x_pkg;

	localparam int unsigned MemWordsDefault = 65536;

	localparam logic [1:0] ModeExec  = 2'd0;
	localparam logic [1:0] ModeWrite = 2'd1;
	localparam logic [1:0] ModeSetPc = 2'd2;
	localparam logic [1:0] ModeNop   = 2'd3;

	localparam logic [3:0] OpBr   = 4'h0;
	localparam logic [3:0] OpAdd  = 4'h1;
	localparam logic [3:0] OpLd   = 4'h2;
	localparam logic [3:0] OpSt   = 4'h3;
	localparam logic [3:0] OpJsr  = 4'h4;
	localparam logic [3:0] OpAnd  = 4'h5;
	localparam logic [3:0] OpLdr  = 4'h6;
	localparam logic [3:0] OpStr  = 4'h7;
	localparam logic [3:0] OpRti  = 4'h8;
	localparam logic [3:0] OpNot  = 4'h9;
	localparam logic [3:0] OpLdi  = 4'hA;
	localparam logic [3:0] OpSti  = 4'hB;
	localparam logic [3:0] OpJmp  = 4'hC;
	localparam logic [3:0] OpRes  = 4'hD;
	localparam logic [3:0] OpLea  = 4'hE;
	localparam logic [3:0] OpTrap = 4'hF;

	localparam logic [15:0] PcReset = 16'h3000;
	localparam logic [2:0]  CcZero  = 3'd2;
	localparam logic [2:0]  CcNeg   = 3'd4;
	localparam logic [2:0]  CcPos   = 3'd1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] instruction;
		logic [15:0] load_address;
		logic [15:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pc_after;
		logic [2:0]  cond_bits;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_written;
		logic [15:0] mem_address;
		logic [15:0] mem_value;
		logic        trap_taken;
		logic [7:0]  trap_vector;
		logic        illegal_op;
	} out_item_t;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		logic [2:0] c;
		if (v[15]) c = CcNeg;
		else if (v == 16'd0) c = CcZero;
		else c = CcPos;
		return c;
	endfunction

endpackage
`default_nettype wire

// File: sv/educational_cpu_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// educational_cpu_execute_unit
// LC-3 execute unit with word memory.
//
// One input channel (in_valid/in_ready, payload in_item) takes an item that
// executes an instruction, writes a memory word or sets the PC. One output
// channel (out_valid/out_ready, payload out_item) gives one result per item.
// Register ops, branches, jumps, stores, traps, memory writes and set-PC items
// complete on acceptance; LD, LDR and STI add a read step in ST_RD1 and LDI a
// second one in ST_OUT, as memory reads are registered (one dependent read per
// cycle). The result is registered and valid in the cycle after the item's last
// step. A new item is accepted in the cycle the previous result leaves, so items
// without a memory read stream back to back while the receiver takes every
// result. Reset sets PC to 0x3000, the condition code to Z and all registers to
// 0; memory contents stay undefined until written. When the receiver stalls, the
// result holds and no new item is accepted until it is taken.
// ----------------------------------------------------------------------------
module educational_cpu_execute_unit #(
	parameter int unsigned MemWords = lc3x_pkg::MemWordsDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire lc3x_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output lc3x_pkg::out_item_t      out_item
);

	localparam int unsigned AW = $clog2(MemWords);

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [15:0]   wdata, rdata;

	lc3x_core #(.MemWords(MemWords)) u_core (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.res_valid(out_valid), .res_ready(out_ready), .res_item(out_item),
		.mem_we(we), .mem_waddr(waddr), .mem_wdata(wdata),
		.mem_raddr(raddr), .mem_rdata(rdata)
	);

	lc3x_ram #(.Width(16), .Depth(MemWords)) u_mem (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

endmodule
`default_nettype wire

// File: sv/lc3x_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lc3x_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: sv/lc3x_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lc3x_core
// Sequencer: register file, PC, condition code and the memory access steps.
// ----------------------------------------------------------------------------
module lc3x_core #(
	parameter int unsigned MemWords = lc3x_pkg::MemWordsDefault
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire lc3x_pkg::in_item_t          in_item,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output lc3x_pkg::out_item_t              res_item,
	output logic                             mem_we,
	output logic [$clog2(MemWords)-1:0]      mem_waddr,
	output logic [15:0]                      mem_wdata,
	output logic [$clog2(MemWords)-1:0]      mem_raddr,
	input  wire logic [15:0]                 mem_rdata
);

	localparam int unsigned AW = $clog2(MemWords);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RD1   = 3'b010,
		ST_OUT   = 3'b100
	} state_t;

	state_t state_q;
	logic [15:0] regs_q [8];
	logic [15:0] pc_q;
	logic [2:0]  cc_q;
	logic [15:0] ins_q;

	// decode of the incoming instruction
	logic [3:0]  op;
	logic [2:0]  dr, sr1, sr2;
	logic [15:0] a, b, off9, off6, off11, pc1;
	assign op   = in_item.instruction[15:12];
	assign dr   = in_item.instruction[11:9];
	assign sr1  = in_item.instruction[8:6];
	assign sr2  = in_item.instruction[2:0];
	assign a    = regs_q[sr1];
	assign off9 = {{7{in_item.instruction[8]}}, in_item.instruction[8:0]};
	assign off6 = {{10{in_item.instruction[5]}}, in_item.instruction[5:0]};
	assign off11 = {{5{in_item.instruction[10]}}, in_item.instruction[10:0]};
	assign pc1  = pc_q + 16'd1;
	assign b    = in_item.instruction[5] ?
		{{11{in_item.instruction[4]}}, in_item.instruction[4:0]} : regs_q[sr2];

	logic [15:0] ea;
	always_comb begin
		ea = pc1 + off9;
		if (op == lc3x_pkg::OpLdr || op == lc3x_pkg::OpStr) ea = a + off6;
	end

	logic accept;
	assign in_ready = (state_q == ST_IDLE) && (!res_valid || res_ready);
	assign accept = in_valid && in_ready;

	logic [2:0] ins_op_dr;
	assign ins_op_dr = ins_q[11:9];

	// read address mux: first read from decode, second from memory data
	always_comb begin
		mem_raddr = ea[AW-1:0];
		if (state_q == ST_RD1) mem_raddr = mem_rdata[AW-1:0];
	end

	// sequence and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= lc3x_pkg::PcReset;
			cc_q      <= lc3x_pkg::CcZero;
			res_valid <= 1'b0;
			res_item  <= '0;
			ins_q     <= 16'd0;
			for (int i = 0; i < 8; i++) regs_q[i] <= 16'd0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ins_q <= in_item.instruction;
						res_item <= '0;
						res_item.pc_after <= pc_q;
						res_item.cond_bits <= cc_q;
						if (in_item.mode == lc3x_pkg::ModeSetPc) begin
							pc_q <= in_item.load_value;
							res_item.pc_after <= in_item.load_value;
							res_valid <= 1'b1;
						end else if (in_item.mode == lc3x_pkg::ModeExec) begin
							pc_q <= pc1;
							res_item.pc_after <= pc1;
							res_valid <= 1'b1;
							unique case (op)
								lc3x_pkg::OpAdd, lc3x_pkg::OpAnd, lc3x_pkg::OpNot,
								lc3x_pkg::OpLea: begin
									logic [15:0] v;
									if (op == lc3x_pkg::OpAdd) v = a + b;
									else if (op == lc3x_pkg::OpAnd) v = a & b;
									else if (op == lc3x_pkg::OpNot) v = ~a;
									else v = pc1 + off9;
									regs_q[dr] <= v;
									cc_q <= lc3x_pkg::cc_of(v);
									res_item.cond_bits <= lc3x_pkg::cc_of(v);
									res_item.reg_written <= 1'b1;
									res_item.reg_index <= dr;
									res_item.reg_value <= v;
								end
								lc3x_pkg::OpBr: begin
									if ((dr & cc_q) != 3'd0) begin
										pc_q <= pc1 + off9;
										res_item.pc_after <= pc1 + off9;
									end
								end
								lc3x_pkg::OpJmp: begin
									pc_q <= a;
									res_item.pc_after <= a;
								end
								lc3x_pkg::OpJsr, lc3x_pkg::OpTrap: begin
									logic [15:0] t;
									t = pc1;
									if (op == lc3x_pkg::OpJsr)
										t = in_item.instruction[11] ? pc1 + off11 : a;
									regs_q[7] <= pc1;
									pc_q <= t;
									res_item.pc_after <= t;
									res_item.reg_written <= 1'b1;
									res_item.reg_index <= 3'd7;
									res_item.reg_value <= pc1;
									if (op == lc3x_pkg::OpTrap) begin
										res_item.trap_taken <= 1'b1;
										res_item.trap_vector <= in_item.instruction[7:0];
									end
								end
								lc3x_pkg::OpSt, lc3x_pkg::OpStr: begin
									res_item.mem_written <= 1'b1;
									res_item.mem_address <= 16'(ea[AW-1:0]);
									res_item.mem_value <= regs_q[dr];
								end
								lc3x_pkg::OpLd, lc3x_pkg::OpLdr, lc3x_pkg::OpLdi,
								lc3x_pkg::OpSti: begin
									res_valid <= 1'b0;
									state_q <= ST_RD1;
								end
								default: res_item.illegal_op <= 1'b1;
							endcase
						end else begin
							res_valid <= 1'b1;
						end
					end
				end
				// first read word: pointer for LDI/STI, loaded word for LD/LDR
				ST_RD1: begin
					unique case (ins_q[15:12])
						lc3x_pkg::OpLdi: state_q <= ST_OUT;
						lc3x_pkg::OpSti: begin
							res_item.mem_written <= 1'b1;
							res_item.mem_address <= 16'(mem_rdata[AW-1:0]);
							res_item.mem_value <= regs_q[ins_op_dr];
							res_valid <= 1'b1;
							state_q <= ST_IDLE;
						end
						default: begin
							regs_q[ins_op_dr] <= mem_rdata;
							cc_q <= lc3x_pkg::cc_of(mem_rdata);
							res_item.cond_bits <= lc3x_pkg::cc_of(mem_rdata);
							res_item.reg_written <= 1'b1;
							res_item.reg_index <= ins_op_dr;
							res_item.reg_value <= mem_rdata;
							res_valid <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				// second read word of LDI: write it back
				ST_OUT: begin
					regs_q[ins_op_dr] <= mem_rdata;
					cc_q <= lc3x_pkg::cc_of(mem_rdata);
					res_item.cond_bits <= lc3x_pkg::cc_of(mem_rdata);
					res_item.reg_written <= 1'b1;
					res_item.reg_index <= ins_op_dr;
					res_item.reg_value <= mem_rdata;
					res_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// memory write: loader writes and stores
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = in_item.load_address[AW-1:0];
		mem_wdata = in_item.load_value;
		if (accept && in_item.mode == lc3x_pkg::ModeWrite) begin
			mem_we = 1'b1;
		end else if (accept && in_item.mode == lc3x_pkg::ModeExec &&
				(op == lc3x_pkg::OpSt || op == lc3x_pkg::OpStr)) begin
			mem_we = 1'b1;
			mem_waddr = ea[AW-1:0];
			mem_wdata = regs_q[dr];
		end else if (state_q == ST_RD1 && ins_q[15:12] == lc3x_pkg::OpSti) begin
			mem_we = 1'b1;
			mem_waddr = mem_rdata[AW-1:0];
			mem_wdata = regs_q[ins_op_dr];
		end
	end

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LC-3 execute unit testbench
// Drives instruction, memory-write, set-PC and no-op items through the valid/ready
// input channel and checks each result against an in-bench architectural
// model of registers, PC, condition code and memory. Random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WatchdogLimit = 20000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	lc3x_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_ready;
	lc3x_pkg::out_item_t out_item;

	// architectural model state
	logic [15:0] arch_regs [8];
	logic [15:0] arch_pc;
	logic [2:0]  arch_cc;
	logic [15:0] arch_mem [int];

	lc3x_pkg::out_item_t pending_results[$];
	int                  mismatch_count;
	int                  idle_cycles;

	educational_cpu_execute_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] sign_ext(input logic [15:0] v, input int bits);
		logic [15:0] r;
		r = v;
		for (int k = bits; k < 16; k++) r[k] = v[bits - 1];
		return r;
	endfunction

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		if (v[15]) return lc3x_pkg::CcNeg;
		if (v == 16'd0) return lc3x_pkg::CcZero;
		return lc3x_pkg::CcPos;
	endfunction

	function automatic logic [15:0] model_mem_rd(input logic [15:0] a);
		if (arch_mem.exists(a)) return arch_mem[a];
		return 16'd0;
	endfunction

	// compute the result of one item and advance the model
	function automatic lc3x_pkg::out_item_t execute_item(input lc3x_pkg::in_item_t it);
		lc3x_pkg::out_item_t r;
		logic [15:0] ins, pc, a, b, off9;
		logic [3:0]  op;
		logic [2:0]  dr;
		r = '0;
		ins = it.instruction;
		if (it.mode == lc3x_pkg::ModeWrite) begin
			arch_mem[it.load_address] = it.load_value;
		end else if (it.mode == lc3x_pkg::ModeSetPc) begin
			arch_pc = it.load_value;
		end else if (it.mode == lc3x_pkg::ModeExec) begin
			pc = arch_pc + 16'd1;
			op = ins[15:12];
			dr = ins[11:9];
			a = arch_regs[ins[8:6]];
			off9 = sign_ext(ins, 9);
			case (op)
				lc3x_pkg::OpAdd, lc3x_pkg::OpAnd: begin
					b = ins[5] ? sign_ext(ins, 5) : arch_regs[ins[2:0]];
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = (op == lc3x_pkg::OpAdd) ? a + b : a & b;
				end
				lc3x_pkg::OpNot: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = ~a;
				end
				lc3x_pkg::OpBr: begin
					if ((dr & arch_cc) != 3'd0) pc = pc + off9;
				end
				lc3x_pkg::OpJmp: pc = a;
				lc3x_pkg::OpJsr: begin
					r.reg_written = 1'b1;
					r.reg_index = 3'd7;
					r.reg_value = pc;
					pc = ins[11] ? pc + sign_ext(ins, 11) : a;
				end
				lc3x_pkg::OpLd: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = model_mem_rd(pc + off9);
				end
				lc3x_pkg::OpLdi: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = model_mem_rd(model_mem_rd(pc + off9));
				end
				lc3x_pkg::OpLdr: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = model_mem_rd(a + sign_ext(ins, 6));
				end
				lc3x_pkg::OpLea: begin
					r.reg_written = 1'b1;
					r.reg_index = dr;
					r.reg_value = pc + off9;
				end
				lc3x_pkg::OpSt, lc3x_pkg::OpSti, lc3x_pkg::OpStr: begin
					r.mem_written = 1'b1;
					r.mem_value = arch_regs[dr];
					if (op == lc3x_pkg::OpSt) r.mem_address = pc + off9;
					else if (op == lc3x_pkg::OpSti) r.mem_address = model_mem_rd(pc + off9);
					else r.mem_address = a + sign_ext(ins, 6);
				end
				lc3x_pkg::OpTrap: begin
					r.reg_written = 1'b1;
					r.reg_index = 3'd7;
					r.reg_value = pc;
					r.trap_taken = 1'b1;
					r.trap_vector = ins[7:0];
				end
				default: r.illegal_op = 1'b1;
			endcase
			if (r.mem_written) arch_mem[r.mem_address] = r.mem_value;
			if (r.reg_written) begin
				arch_regs[r.reg_index] = r.reg_value;
				if (op != lc3x_pkg::OpJsr && op != lc3x_pkg::OpTrap)
					arch_cc = flags_of(r.reg_value);
			end
			arch_pc = pc;
		end
		r.pc_after = arch_pc;
		r.cond_bits = arch_cc;
		return r;
	endfunction

	// send one item after a random gap and record its expected result
	task automatic send_item(input lc3x_pkg::in_item_t it);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(execute_item(it));
	endtask

	task automatic send_exec(input logic [15:0] ins);
		lc3x_pkg::in_item_t it;
		it = '{mode: lc3x_pkg::ModeExec, instruction: ins, load_address: 16'($urandom),
			load_value: 16'($urandom)};
		send_item(it);
	endtask

	task automatic send_mem_write(input logic [15:0] addr, input logic [15:0] val);
		lc3x_pkg::in_item_t it;
		it = '{mode: lc3x_pkg::ModeWrite, instruction: 16'($urandom), load_address: addr,
			load_value: val};
		send_item(it);
	endtask

	task automatic send_set_pc(input logic [15:0] val);
		lc3x_pkg::in_item_t it;
		it = '{mode: lc3x_pkg::ModeSetPc, instruction: 16'($urandom),
			load_address: 16'($urandom), load_value: val};
		send_item(it);
	endtask

	// fill a window around an address so loads from it read written words
	task automatic fill_window(input logic [15:0] base, input int span);
		for (int k = -span; k <= span; k++) send_mem_write(base + 16'(k), 16'($urandom));
	endtask

	task automatic test_directed;
		lc3x_pkg::in_item_t it;
		send_exec({lc3x_pkg::OpAnd, 3'd0, 3'd0, 1'b1, 5'd0});
		send_exec({lc3x_pkg::OpAdd, 3'd1, 3'd0, 1'b1, 5'h0F});
		send_exec({lc3x_pkg::OpAdd, 3'd2, 3'd1, 1'b1, 5'h10});
		send_exec({lc3x_pkg::OpAdd, 3'd3, 3'd1, 1'b0, 2'b00, 3'd2});
		send_exec({lc3x_pkg::OpAnd, 3'd4, 3'd3, 1'b0, 2'b00, 3'd1});
		send_exec({lc3x_pkg::OpNot, 3'd5, 3'd0, 6'h3F});
		send_exec({lc3x_pkg::OpBr, 3'b000, 9'h0FF});
		send_exec({lc3x_pkg::OpBr, 3'b111, 9'h100});
		send_exec({lc3x_pkg::OpLea, 3'd6, 9'h1FF});
		send_set_pc(16'hFFFF);
		send_exec({lc3x_pkg::OpTrap, 4'hF, 8'hFF});
		send_exec({lc3x_pkg::OpTrap, 4'h0, 8'h00});
		send_exec({lc3x_pkg::OpRti, 12'hFFF});
		send_exec({lc3x_pkg::OpRes, 12'h000});
		// JSRR through R7 reads the old R7
		send_exec({lc3x_pkg::OpJsr, 1'b0, 2'b00, 3'd7, 6'd0});
		send_exec({lc3x_pkg::OpJsr, 1'b1, 11'h7FF});
		send_exec({lc3x_pkg::OpJmp, 3'd0, 3'd5, 6'd0});
		send_set_pc(16'h0000);
		fill_window(16'h0000, 2);
		send_exec({lc3x_pkg::OpLd, 3'd1, 9'h000});
		send_exec({lc3x_pkg::OpSt, 3'd5, 9'h000});
		it = '{mode: lc3x_pkg::ModeNop, instruction: 16'hFFFF, load_address: 16'hFFFF,
			load_value: 16'hFFFF};
		send_item(it);
	endtask

	// well-formed memory sequences: write pointers and data, then use them
	task automatic test_memory_ops(input int count);
		logic [15:0] ins, ptr, ea;
		logic [2:0]  base_reg;
		int          pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 5);
			ins = 16'($urandom);
			base_reg = ins[8:6];
			ea = arch_pc + 16'd1 + sign_ext(ins, 9);
			case (pick)
				0, 1: begin
					send_mem_write(ea, 16'($urandom));
					ins[15:12] = (pick == 0) ? lc3x_pkg::OpLd : lc3x_pkg::OpSt;
				end
				2: begin
					// keep the pointer apart from its own slot
					do ptr = 16'($urandom); while (ptr == ea);
					send_mem_write(ea, ptr);
					send_mem_write(ptr, 16'($urandom));
					ins[15:12] = $urandom_range(0, 1) ? lc3x_pkg::OpLdi : lc3x_pkg::OpSti;
				end
				3: begin
					send_mem_write(arch_regs[base_reg] + sign_ext(ins, 6), 16'($urandom));
					ins[15:12] = lc3x_pkg::OpLdr;
				end
				4: ins[15:12] = lc3x_pkg::OpStr;
				default: begin
					send_mem_write(16'($urandom), 16'($urandom));
					ins[15:12] = lc3x_pkg::OpSt;
				end
			endcase
			send_exec(ins);
		end
	endtask

	// random non-load instructions mixed with set-PC items and unused mode
	task automatic test_random_exec(input int count);
		logic [15:0]        ins;
		lc3x_pkg::in_item_t it;
		for (int n = 0; n < count; n++) begin
			ins = 16'($urandom);
			while (ins[15:12] == lc3x_pkg::OpLd || ins[15:12] == lc3x_pkg::OpLdi
					|| ins[15:12] == lc3x_pkg::OpLdr || ins[15:12] == lc3x_pkg::OpSti)
				ins[15:12] = 4'($urandom);
			case ($urandom_range(0, 19))
				0: send_set_pc(16'($urandom));
				1: begin
					it = '{mode: lc3x_pkg::ModeNop, instruction: 16'($urandom),
						load_address: 16'($urandom), load_value: 16'($urandom)};
					send_item(it);
				end
				default: send_exec(ins);
			endcase
		end
	endtask

	// take each result after a random wait and check it against the oldest expectation
	initial begin
		lc3x_pkg::out_item_t want;
		int                  gap;
		out_ready = 1'b0;
		forever begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h", out_item);
			end else begin
				want = pending_results.pop_front();
				if (want !== out_item) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p actual %p", want, out_item);
				end
			end
		end
	end

	// count cycles without any handshake
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WatchdogLimit) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		mismatch_count = 0;
		for (int k = 0; k < 8; k++) arch_regs[k] = 16'd0;
		arch_pc = lc3x_pkg::PcReset;
		arch_cc = lc3x_pkg::CcZero;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_memory_ops(400);
		test_random_exec(600);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
